// ----- design/esc_pkg.sv -----
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and character-class functions for the expression
// syntax checker.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned DepthBits  = 16;
  localparam int unsigned MaxDigits  = 16;
  localparam int unsigned NumOps     = 7;
  localparam int unsigned CharW      = 8;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned DigitCntW  = 5;
  localparam int unsigned OpFieldW   = NumOps * CharW;

  // operator slots inside operator_chars
  localparam int unsigned OpOpen  = 0;
  localparam int unsigned OpClose = 1;
  localparam int unsigned OpPlus  = 2;
  localparam int unsigned OpMinus = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OPERATOR_CHARS = 2'd0,
    REG_DIGIT_LOW      = 2'd1,
    REG_DIGIT_HIGH     = 2'd2,
    REG_DIGIT_COUNT    = 2'd3
  } cfg_reg_e;

  localparam logic [OpFieldW-1:0]  RstOperatorChars = 56'h25_2F_2A_2D_2B_29_28;
  localparam logic [CfgDataW-1:0]  RstDigitLow      = 64'h3736_3534_3332_3130;
  localparam logic [CfgDataW-1:0]  RstDigitHigh     = 64'h0000_0000_0000_3938;
  localparam logic [DigitCntW-1:0] RstDigitCount    = 5'd10;

  typedef logic [CharW-1:0] char_t;

  typedef struct packed {
    char_t [NumOps-1:0]    ops;
    char_t [MaxDigits-1:0] digits;
    logic  [MaxDigits-1:0] used;
    logic                  config_err;
  } cfg_t;

  function automatic logic is_op(char_t c, cfg_t cfg);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NumOps; k++) begin
      hit = hit | (cfg.ops[k] == c);
    end
    return hit;
  endfunction

  function automatic logic is_digit(char_t c, cfg_t cfg);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < MaxDigits; i++) begin
      hit = hit | (cfg.used[i] && (cfg.digits[i] == c));
    end
    return hit;
  endfunction

endpackage

// ----- design/esc_cfg.sv -----
// ----------------------------------------------------------------------------
// esc_cfg
// Configuration registers, digits-in-use mask and a registered check for
// repeated or overlapping configured characters.
// ----------------------------------------------------------------------------
module esc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [esc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [esc_pkg::CfgDataW-1:0] cfg_data_i,
  output esc_pkg::cfg_t                cfg_o
);
  import esc_pkg::*;

  logic [OpFieldW-1:0]  ops_q;
  logic [CfgDataW-1:0]  dig_lo_q;
  logic [CfgDataW-1:0]  dig_hi_q;
  logic [DigitCntW-1:0] dig_cnt_q;
  logic                 cfg_err_q;
  logic                 cfg_err_d;
  logic [DigitCntW-1:0] n_used;
  cfg_t                 cfg_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ops_q     <= RstOperatorChars;
      dig_lo_q  <= RstDigitLow;
      dig_hi_q  <= RstDigitHigh;
      dig_cnt_q <= RstDigitCount;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_OPERATOR_CHARS: ops_q     <= cfg_data_i[OpFieldW-1:0];
        REG_DIGIT_LOW:      dig_lo_q  <= cfg_data_i;
        REG_DIGIT_HIGH:     dig_hi_q  <= cfg_data_i;
        REG_DIGIT_COUNT:    dig_cnt_q <= cfg_data_i[DigitCntW-1:0];
        default: ;
      endcase
    end
  end

  // clamp the digit count into 1 .. MaxDigits
  always_comb begin
    if (dig_cnt_q == '0) begin
      n_used = DigitCntW'(1);
    end else if (dig_cnt_q > DigitCntW'(MaxDigits)) begin
      n_used = DigitCntW'(MaxDigits);
    end else begin
      n_used = dig_cnt_q;
    end
  end

  always_comb begin
    cfg_raw            = '0;
    cfg_raw.ops        = ops_q;
    cfg_raw.digits     = {dig_hi_q, dig_lo_q};
    for (int i = 0; i < MaxDigits; i++) begin
      cfg_raw.used[i] = DigitCntW'(i) < n_used;
    end
    cfg_raw.config_err = cfg_err_q;
  end

  // flag duplicate operators, operators that are digits, duplicate digits
  always_comb begin
    cfg_err_d = 1'b0;
    for (int i = 0; i < NumOps; i++) begin
      for (int j = i + 1; j < NumOps; j++) begin
        cfg_err_d = cfg_err_d | (cfg_raw.ops[i] == cfg_raw.ops[j]);
      end
      cfg_err_d = cfg_err_d | is_digit(cfg_raw.ops[i], cfg_raw);
    end
    for (int i = 0; i < MaxDigits; i++) begin
      for (int j = i + 1; j < MaxDigits; j++) begin
        cfg_err_d = cfg_err_d | (cfg_raw.used[j] &&
                                 (cfg_raw.digits[i] == cfg_raw.digits[j]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_err_q <= 1'b0;
    end else begin
      cfg_err_q <= cfg_err_d;
    end
  end

  assign cfg_o = cfg_raw;

endmodule

// ----- design/esc_core.sv -----
// ----------------------------------------------------------------------------
// esc_core
// Per-character syntax checks: lookahead pair rules, set membership,
// parenthesis depth and the sticky error flag; forms the verdict.
// ----------------------------------------------------------------------------
module esc_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic [esc_pkg::CharW-1:0] char_i,
  input  logic                      last_i,
  input  esc_pkg::cfg_t             cfg_i,
  output logic                      invalid_o
);
  import esc_pkg::*;

  char_t                held_q;
  logic                 held_valid_q;
  logic [DepthBits-1:0] depth_q;
  logic [DepthBits-1:0] depth_d;
  logic                 err_q;
  logic                 err_d;

  logic c_op, c_dig, c_close;
  logic n_op, n_dig, n_open, n_close, n_plus, n_minus;
  logic pair_err, self_err;

  always_comb begin
    c_op    = is_op(held_q, cfg_i);
    c_dig   = is_digit(held_q, cfg_i);
    c_close = held_q == cfg_i.ops[OpClose];
    n_op    = is_op(char_i, cfg_i);
    n_dig   = is_digit(char_i, cfg_i);
    n_open  = char_i == cfg_i.ops[OpOpen];
    n_close = char_i == cfg_i.ops[OpClose];
    n_plus  = char_i == cfg_i.ops[OpPlus];
    n_minus = char_i == cfg_i.ops[OpMinus];
  end

  // rules between the held character and the new one
  assign pair_err = held_valid_q &&
                    ((c_op && !c_close && n_op && !n_plus && !n_minus && !n_open) ||
                     (c_close && n_open) ||
                     (c_close && n_dig) ||
                     (c_dig && n_open));

  always_comb begin
    self_err = !n_dig && !n_op;
    depth_d  = depth_q;
    priority if (n_open) begin
      if (depth_q == '1) begin
        self_err = 1'b1;
      end else begin
        depth_d = depth_q + DepthBits'(1);
      end
    end else if (n_close) begin
      if (depth_q == '0) begin
        self_err = 1'b1;
      end else begin
        depth_d = depth_q - DepthBits'(1);
      end
    end else begin
      depth_d = depth_q;
    end
  end

  assign err_d     = err_q | pair_err | self_err;
  assign invalid_o = err_d | (depth_d != '0) | (!n_dig && !n_close) | cfg_i.config_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      held_valid_q <= 1'b0;
      depth_q      <= '0;
      err_q        <= 1'b0;
    end else if (fire_i) begin
      if (last_i) begin
        // verdict issued: start the next expression clean
        held_q       <= '0;
        held_valid_q <= 1'b0;
        depth_q      <= '0;
        err_q        <= 1'b0;
      end else begin
        held_q       <= char_i;
        held_valid_q <= 1'b1;
        depth_q      <= depth_d;
        err_q        <= err_d;
      end
    end
  end

endmodule

// ----- design/expression_syntax_checker.sv -----
// ----------------------------------------------------------------------------
// expression_syntax_checker
// Streaming syntax checker for arithmetic expressions, one character a beat.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one character per beat in s_axis_tdata[7:0]; s_axis_tlast
//   marks the final character of an expression.
//   Master stream: one verdict beat per expression, issued for the tlast
//   character; m_axis_tdata[0] is 1 for invalid syntax, 0 for valid.
//   Config port: cfg_we_i writes cfg_data_i to register cfg_index_i
//   (0 operator chars, 1 digits low, 2 digits high, 3 digit count).
//   Write only while no expression is in flight.
// Timing:
//   A beat is registered on input, checked against the held lookahead
//   character, depth counter and error flag, and the verdict lands in the
//   output register. One character per cycle sustained while the verdict
//   slot is free; a waiting final character holds the input.
// Reset and stall:
//   Reset clears the state and loads the default configuration. When the
//   receiver stalls, non-final characters keep flowing; a final character
//   waits in the input register until the verdict slot frees.
// ----------------------------------------------------------------------------
module expression_syntax_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] expr_char
  input  logic                         s_axis_tlast,   // is_last
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // [0] invalid, [7:1] zero
  input  logic                         cfg_we_i,
  input  logic [esc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [esc_pkg::CfgDataW-1:0] cfg_data_i
);
  import esc_pkg::*;

  cfg_t  cfg;
  logic  in_valid_q;
  char_t in_char_q;
  logic  in_last_q;
  logic  fire;
  logic  verdict;
  logic  out_valid_q;
  logic  out_invalid_q;

  esc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // a final character needs a free verdict slot
  assign fire          = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  esc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .char_i    (in_char_q),
    .last_i    (in_last_q),
    .cfg_i     (cfg),
    .invalid_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_last_q) begin
      out_invalid_q <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_invalid_q};

endmodule

// ----- design/esc_assert.sv -----
// ----------------------------------------------------------------------------
// esc_assert
// Port-level checks for the expression syntax checker, bound to the top.
// ----------------------------------------------------------------------------
module esc_assert (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // input only backs up behind a blocked verdict beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while verdict slot free");

  // final character taken with idle output yields a verdict beat
  a_verdict_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast && !m_axis_tvalid)
      |-> ##2 m_axis_tvalid)
    else $error("verdict beat missing after final character");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'b0))
    else $error("verdict padding bits not zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled verdict beat changed");

endmodule

bind expression_syntax_checker esc_assert u_esc_assert (.*);

// ----- verif/tb_expression_syntax_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_expression_syntax_checker
// Self-checking bench for the streaming expression syntax checker. A local
// model of the checker (lookahead pair rules, depth counter, sticky error,
// configuration sanity) predicts the verdict of every expression. Stimulus
// covers hand-picked corner cases, register extremes, deep nesting with
// unbalanced closes and random well-formed expressions with corrupted and
// noise runs. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_expression_syntax_checker;
  import esc_pkg::*;

  localparam int unsigned SlotModulo  = 6;
  localparam int unsigned RandomItems = 600;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned NestDepth   = 24;

  typedef char_t char_q_t[$];

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // [7:0] expr_char
  logic                 s_axis_tlast;   // is_last
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;   // [0] invalid, [7:1] zero
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  // model copy of the registers
  logic [OpFieldW-1:0]  mdl_ops;
  logic [CfgDataW-1:0]  mdl_dig_lo;
  logic [CfgDataW-1:0]  mdl_dig_hi;
  logic [DigitCntW-1:0] mdl_dig_cnt;

  // model copy of the expression state
  char_t                held_c;
  bit                   held_ok;
  logic [DepthBits-1:0] paren_lvl;
  bit                   err_flag;

  bit          verdict_q[$];
  int unsigned in_gap_max;
  int unsigned out_gap_max;
  int unsigned fail_cnt;
  int unsigned char_cnt;
  int unsigned expr_cnt;
  int unsigned invalid_cnt;
  int unsigned write_cnt;

  expression_syntax_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Checker model
  // --------------------------------------------------------------------------
  function automatic char_t op_byte(int unsigned k);
    return mdl_ops[8*k +: 8];
  endfunction

  function automatic char_t digit_byte(int unsigned i);
    if (i < 8) return mdl_dig_lo[8*i +: 8];
    return mdl_dig_hi[8*(i-8) +: 8];
  endfunction

  function automatic int unsigned digits_in_use();
    if (mdl_dig_cnt == '0) return 1;
    if (mdl_dig_cnt > DigitCntW'(MaxDigits)) return MaxDigits;
    return 32'(mdl_dig_cnt);
  endfunction

  function automatic bit is_operator_char(char_t c);
    for (int unsigned k = 0; k < NumOps; k++) begin
      if (op_byte(k) == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit is_digit_char(char_t c);
    for (int unsigned i = 0; i < digits_in_use(); i++) begin
      if (digit_byte(i) == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // rules between a character and the one that follows it
  function automatic bit pair_bad(char_t c, char_t n);
    if (is_operator_char(c)) begin
      if (c != op_byte(OpClose)) begin
        if (is_operator_char(n) && n != op_byte(OpPlus) && n != op_byte(OpMinus) &&
            n != op_byte(OpOpen)) return 1'b1;
      end else if (n == op_byte(OpOpen)) begin
        return 1'b1;
      end
    end
    if (c == op_byte(OpClose) && is_digit_char(n)) return 1'b1;
    if (is_digit_char(c) && n == op_byte(OpOpen)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit config_bad();
    for (int unsigned i = 0; i < NumOps; i++) begin
      for (int unsigned j = i + 1; j < NumOps; j++) begin
        if (op_byte(i) == op_byte(j)) return 1'b1;
      end
      if (is_digit_char(op_byte(i))) return 1'b1;
    end
    for (int unsigned i = 0; i < digits_in_use(); i++) begin
      for (int unsigned j = i + 1; j < digits_in_use(); j++) begin
        if (digit_byte(i) == digit_byte(j)) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Advance the model by one character; returns 1 when a verdict is due.
  function automatic bit advance_checker(input char_t c, input bit last, output bit verdict);
    verdict = 1'b0;
    if (held_ok && pair_bad(held_c, c)) err_flag = 1'b1;
    if (!is_digit_char(c) && !is_operator_char(c)) err_flag = 1'b1;
    if (c == op_byte(OpOpen)) begin
      if (paren_lvl == '1) err_flag = 1'b1;
      else paren_lvl++;
    end else if (c == op_byte(OpClose)) begin
      if (paren_lvl == '0) err_flag = 1'b1;
      else paren_lvl--;
    end
    if (!last) begin
      held_c  = c;
      held_ok = 1'b1;
      return 1'b0;
    end
    verdict = err_flag || (paren_lvl != '0) ||
              (!is_digit_char(c) && c != op_byte(OpClose)) || config_bad();
    held_c    = '0;
    held_ok   = 1'b0;
    paren_lvl = '0;
    err_flag  = 1'b0;
    return 1'b1;
  endfunction

  function automatic void reset_model();
    mdl_ops     = RstOperatorChars;
    mdl_dig_lo  = RstDigitLow;
    mdl_dig_hi  = RstDigitHigh;
    mdl_dig_cnt = RstDigitCount;
    held_c      = '0;
    held_ok     = 1'b0;
    paren_lvl   = '0;
    err_flag    = 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap_limit();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 18;
    endcase
  endfunction

  function automatic char_q_t from_text(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Well-formed expression over the characters currently configured.
  function automatic char_q_t build_expr(int unsigned max_len);
    char_q_t     q;
    int unsigned lvl;
    int unsigned target;
    int unsigned r;
    int unsigned run;
    bit          need_operand;
    lvl          = 0;
    need_operand = 1'b1;
    target       = $urandom_range(1, max_len);
    while (need_operand || q.size() < target) begin
      r = $urandom_range(0, 9);
      if (need_operand) begin
        if (r < 2 && lvl < 6 && q.size() < target) begin
          q.push_back(op_byte(OpOpen));
          lvl++;
        end else if (r == 2 && q.size() < target) begin
          // unary sign
          q.push_back(op_byte($urandom_range(0, 1) ? OpPlus : OpMinus));
        end else begin
          run = $urandom_range(1, 3);
          repeat (run) q.push_back(digit_byte($urandom_range(0, digits_in_use() - 1)));
          need_operand = 1'b0;
        end
      end else if (lvl > 0 && r < 3) begin
        q.push_back(op_byte(OpClose));
        lvl--;
      end else begin
        q.push_back(op_byte($urandom_range(OpPlus, SlotModulo)));
        need_operand = 1'b1;
      end
    end
    repeat (lvl) q.push_back(op_byte(OpClose));
    return q;
  endfunction

  function automatic char_q_t corrupt(char_q_t q);
    int unsigned pos;
    pos = $urandom_range(0, q.size() - 1);
    case ($urandom_range(0, 3))
      0: q[pos] = char_t'($urandom_range(0, 255));
      1: q.insert(pos, op_byte($urandom_range(0, SlotModulo)));
      2: begin
        if (q.size() > 1) q.delete(pos);
        else q[pos] = op_byte(OpClose);
      end
      default: q.insert(pos, op_byte(OpOpen));
    endcase
    return q;
  endfunction

  function automatic char_q_t noise_run();
    char_q_t q;
    repeat ($urandom_range(1, 6)) q.push_back(char_t'($urandom_range(0, 255)));
    return q;
  endfunction

  // Enter and leave at a falling edge; tvalid stays high for a back-to-back beat.
  task automatic send_char(input char_t c, input bit last);
    int unsigned gap;
    bit          verdict;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    char_cnt++;
    if (advance_checker(c, last, verdict)) begin
      verdict_q.push_back(verdict);
      expr_cnt++;
      if (verdict) invalid_cnt++;
    end
    @(negedge clk_i);
  endtask

  task automatic send_expr(input char_q_t q);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
  endtask

  // Drop tvalid, wait for every verdict, then let the pipeline empty.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    write_cnt++;
  endtask

  task automatic load_config(input logic [CfgDataW-1:0] ops, input logic [CfgDataW-1:0] lo,
                             input logic [CfgDataW-1:0] hi, input logic [CfgDataW-1:0] cnt);
    drain_block();
    write_reg(REG_OPERATOR_CHARS, ops);
    write_reg(REG_DIGIT_LOW, lo);
    write_reg(REG_DIGIT_HIGH, hi);
    write_reg(REG_DIGIT_COUNT, cnt);
    cfg_we_i    <= 1'b0;
    mdl_ops     = ops[OpFieldW-1:0];
    mdl_dig_lo  = lo;
    mdl_dig_hi  = hi;
    mdl_dig_cnt = cnt[DigitCntW-1:0];
    @(negedge clk_i);
  endtask

  task automatic load_defaults();
    load_config(CfgDataW'(RstOperatorChars), RstDigitLow, RstDigitHigh,
                CfgDataW'(RstDigitCount));
  endtask

  // Distinct character sets; a flawed set copies one byte over another.
  task automatic random_config(input bit flawed);
    char_t                pool [23];
    bit                   preset [23];
    bit                   taken [256];
    logic [CfgDataW-1:0]  ops;
    logic [CfgDataW-1:0]  lo;
    logic [CfgDataW-1:0]  hi;
    logic [CfgDataW-1:0]  cnt_word;
    int unsigned          a;
    int unsigned          b;
    char_t                c;
    taken  = '{default: 1'b0};
    preset = '{default: 1'b0};
    if ($urandom_range(0, 2) == 0) begin
      // put the zero and all-ones bytes to work
      a = $urandom_range(0, NumOps - 1);
      b = $urandom_range(NumOps, 22);
      pool[a] = 8'h00;
      pool[b] = 8'hFF;
      preset[a] = 1'b1;
      preset[b] = 1'b1;
      taken[8'h00] = 1'b1;
      taken[8'hFF] = 1'b1;
    end
    for (int i = 0; i < 23; i++) begin
      if (!preset[i]) begin
        do c = char_t'($urandom_range(0, 255)); while (taken[c]);
        taken[c] = 1'b1;
        pool[i]  = c;
      end
    end
    if (flawed) begin
      a = $urandom_range(0, 22);
      do b = $urandom_range(0, 22); while (b == a);
      pool[b] = pool[a];
    end
    ops = {$urandom, $urandom};
    for (int k = 0; k < NumOps; k++) ops[8*k +: 8] = pool[k];
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pool[NumOps + i];
      hi[8*i +: 8] = pool[NumOps + 8 + i];
    end
    cnt_word = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) begin
      cnt_word[DigitCntW-1:0] = DigitCntW'($urandom_range(0, 31));
    end else begin
      cnt_word[DigitCntW-1:0] = DigitCntW'($urandom_range(2, MaxDigits));
    end
    load_config(ops, lo, hi, cnt_word);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    string   cases[$];
    char_q_t q;
    in_gap_max  = 3;
    out_gap_max = 18;
    cases = '{"-(9)%8", "(1)2", "1(2)", "1*/2", ")", ")(", "((0", "3+", "x"};
    foreach (cases[i]) send_expr(from_text(cases[i]));
    q = {8'h00};
    send_expr(q);
    q = {8'hFF};
    send_expr(q);
  endtask

  task automatic test_register_extremes();
    logic [CfgDataW-1:0] ops;
    // every byte all ones: duplicates everywhere, count clamps down
    in_gap_max  = pick_gap_limit();
    out_gap_max = pick_gap_limit();
    load_config('1, '1, '1, '1);
    repeat (3) send_expr(build_expr(8));
    // every byte zero: count clamps up, the zero byte is both kinds
    load_config('0, '0, '0, '0);
    repeat (3) send_expr(build_expr(8));
    // full hex base
    load_config(CfgDataW'(RstOperatorChars), RstDigitLow, 64'h4645_4443_4241_3938,
                CfgDataW'(MaxDigits));
    send_expr(from_text("F0+(A*9)"));
    repeat (3) send_expr(build_expr(12));
    // one digit only
    load_config(CfgDataW'(RstOperatorChars), RstDigitLow, RstDigitHigh, '0);
    send_expr(from_text("0-0"));
    send_expr(from_text("1"));
    repeat (2) send_expr(build_expr(10));
    // zero byte as the close operator
    ops = CfgDataW'(RstOperatorChars);
    ops[8*OpClose +: 8] = 8'h00;
    load_config(ops, RstDigitLow, RstDigitHigh, CfgDataW'(RstDigitCount));
    repeat (4) send_expr(build_expr(12));
    load_defaults();
  endtask

  task automatic test_depth_limits();
    load_defaults();
    in_gap_max  = 0;
    out_gap_max = 18;
    for (int pass = 0; pass < 2; pass++) begin
      // nest deep and unwind; the second pass closes once too often
      repeat (NestDepth) send_char(op_byte(OpOpen), 1'b0);
      send_char(digit_byte(0), 1'b0);
      for (int unsigned n = 1; n <= NestDepth + pass; n++) begin
        send_char(op_byte(OpClose), n == NestDepth + pass);
      end
    end
    // close before any open
    send_expr(from_text(")1"));
  endtask

  task automatic test_random_expressions();
    char_q_t     q;
    int unsigned sent;
    int unsigned phase_end;
    int unsigned kind;
    int unsigned r;
    sent = 0;
    while (sent < RandomItems) begin
      kind = $urandom_range(0, 5);
      if (kind == 0) load_defaults();
      else random_config(kind == 1);
      in_gap_max  = pick_gap_limit();
      out_gap_max = pick_gap_limit();
      phase_end   = sent + $urandom_range(60, 140);
      while (sent < phase_end && sent < RandomItems) begin
        r = $urandom_range(0, 19);
        q = build_expr((r == 0) ? 40 : 12);
        if (r >= 16) q = corrupt(q);
        else if (r == 1) q = noise_run();
        send_expr(q);
        sent += q.size();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: receiver stalls and verdict check
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    bit want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $error("invalid: no verdict expected, got %0b", m_axis_tdata[0]);
        fail_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[0] !== want) begin
          $error("invalid: expected %0b, got %0b", want, m_axis_tdata[0]);
          fail_cnt++;
        end
      end
    end
  end

  // end the run after too many cycles without any beat or write
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL expression_syntax_checker");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_OPERATOR_CHARS;
    cfg_data_i    = '0;
    in_gap_max    = 0;
    out_gap_max   = 0;
    fail_cnt      = 0;
    char_cnt      = 0;
    expr_cnt      = 0;
    invalid_cnt   = 0;
    write_cnt     = 0;
    reset_model();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_register_extremes();
    test_depth_limits();
    test_random_expressions();
    drain_block();

    $display("Checked %0d verdicts (%0d invalid) over %0d characters, %0d register writes.",
             expr_cnt, invalid_cnt, char_cnt, write_cnt);
    $display("Ran corner cases, register extremes, deep nesting and random expressions.");
    if (fail_cnt == 0) begin
      $display("PASS expression_syntax_checker");
    end else begin
      $display("FAIL expression_syntax_checker");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/esc_pkg.sv
design/esc_cfg.sv
design/esc_core.sv
design/expression_syntax_checker.sv
design/esc_assert.sv
verif/tb_expression_syntax_checker.sv
